[rtl/core/bthalloc_pkg.sv]
package bthalloc_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int BLOCK_BYTES_DEF = 4096;

   // table entry layout: taken, first of run, has next
   localparam int ENTRY_W   = 3;
   localparam int ENT_TAKEN = 0;
   localparam int ENT_FIRST = 1;
   localparam int ENT_NEXT  = 2;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOMEM = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // register map
   localparam int         CSR_AW        = 3;
   localparam logic       CSR_HEAP_BASE = 1'b0;
   localparam logic       CSR_BLOCKS    = 1'b1;
   localparam int         BLOCKS_W      = 11;
   localparam logic [10:0] BLOCKS_RESET = 11'd1024;

   typedef struct packed {
      logic        operation;
      logic [31:0] request_bytes;
      logic [31:0] free_address;
   } req_type;

   typedef struct packed {
      logic [31:0] result_address;
      logic [1:0]  status;
   } rsp_type;

endpackage

[rtl/core/block_table_heap_allocator_top.sv]
// First-fit block table heap allocator.
//
// Request channel (req_valid/req_ready/req_data) takes one word per item:
// an allocate (byte count) or a free (start address). Each item gives one
// word on the response channel (rsp_valid/rsp_ready/rsp_data): base address
// and status. heap_base and blocks_in_use are set through the csr_ APB port
// (byte addresses 0 and 4); the user must write them only while the block is
// idle, which the block itself leaves unchecked.
//
// One item is handled at a time. After acceptance a shift turns the byte count
// or the address offset into blocks (BLOCK_BYTES is a power of two). An
// allocate then scans the table one entry per cycle up to the end of the first
// fitting run (at most blocks_in_use entries) and marks the run one entry per
// cycle; a free clears its has-next chain one entry per cycle. A request that
// fails the size or range check after the shift goes straight to the response,
// and an address below heap_base skips the shift as well. The next word can be
// taken in the cycle after the response is loaded. The single table memory
// port pair limits the scan, mark and walk to one entry at a time.
//
// After reset the table is cleared in a pass over all TABLE_DEPTH entries,
// during which req_ready is low. A stalled response waits in the output register;
// the next request is still accepted and held until that word is taken.
module block_table_heap_allocator_top #(
   parameter int TABLE_DEPTH = bthalloc_pkg::TABLE_DEPTH_DEF,
   parameter int BLOCK_BYTES = bthalloc_pkg::BLOCK_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bthalloc_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bthalloc_pkg::rsp_type             rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bthalloc_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   import bthalloc_pkg::*;

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int NW  = $clog2(TABLE_DEPTH + 1);
   localparam int CW  = (NW > BLOCKS_W) ? NW : BLOCKS_W;
   localparam int RW  = $clog2(BLOCK_BYTES);
   localparam int DW  = 33;
   localparam int QW  = DW - RW;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_MARK  = 7'b0010000,
      ST_WALK  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [31:0]   heap_base_ff, heap_base_in;
   logic [BLOCKS_W-1:0] blocks_ff, blocks_in;
   logic          op_ff, op_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] run_ff, run_in;
   logic [NW-1:0] want_ff, want_in;
   logic [NW-1:0] start_ff, start_in;
   logic [31:0]   addr_ff, addr_in;
   logic [31:0]   start_addr_ff, start_addr_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic [1:0]    res_status_ff, res_status_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0] blocks_wide;
   logic [NW-1:0] heap_n;
   logic          csr_wr;
   logic [QW-1:0] quo;
   logic [NW-1:0] idx_nxt, run_inc;
   logic          ent_free;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      heap_base_in = heap_base_ff;
      blocks_in    = blocks_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_HEAP_BASE: heap_base_in = csr_pwdata;
            CSR_BLOCKS:    blocks_in    = csr_pwdata[BLOCKS_W-1:0];
            default:       heap_base_in = heap_base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_HEAP_BASE: csr_prdata = heap_base_ff;
         CSR_BLOCKS:    csr_prdata = {{(32 - BLOCKS_W){1'b0}}, blocks_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // effective heap size, clipped to the table
   assign blocks_wide = CW'(blocks_ff);
   assign heap_n = (blocks_wide < CW'(TABLE_DEPTH)) ? NW'(blocks_wide) : NW'(TABLE_DEPTH);

   // block count: the rounded byte count or the offset shifted by the block size
   assign quo = dvd_ff[DW-1:RW];

   assign idx_nxt  = idx_ff + NW'(1);
   assign run_inc  = run_ff + NW'(1);
   assign ent_free = !ram_rdata[ENT_TAKEN];

   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      dvd_in        = dvd_ff;
      idx_in        = idx_ff;
      run_in        = run_ff;
      want_in       = want_ff;
      start_in      = start_ff;
      addr_in       = addr_ff;
      start_addr_in = start_addr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[AW-1:0];
      ram_wdata     = '0;
      ram_raddr     = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            idx_in = idx_nxt;
            if (idx_nxt == NW'(TABLE_DEPTH)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.operation;
               res_addr_in = 32'd0;
               if (req_data.operation == OP_ALLOC) begin
                  dvd_in   = {1'b0, req_data.request_bytes} + DW'(BLOCK_BYTES - 1);
                  state_in = ST_DIV;
               end else if (req_data.free_address < heap_base_ff) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  dvd_in   = {1'b0, req_data.free_address - heap_base_ff};
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            if (op_ff == OP_ALLOC) begin
               if (quo == '0 || quo > QW'(heap_n)) begin
                  res_status_in = STATUS_NOMEM;
                  state_in      = ST_DONE;
               end else begin
                  want_in   = quo[NW-1:0];
                  idx_in    = '0;
                  run_in    = '0;
                  addr_in   = heap_base_ff;
                  ram_raddr = '0;
                  state_in  = ST_SCAN;
               end
            end else begin
               if (quo >= QW'(heap_n)) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  idx_in    = quo[NW-1:0];
                  ram_raddr = quo[AW-1:0];
                  state_in  = ST_WALK;
               end
            end
         end

         // read data of idx_ff arrives now; the next entry is read ahead
         ST_SCAN: begin
            addr_in   = addr_ff + 32'(BLOCK_BYTES);
            idx_in    = idx_nxt;
            ram_raddr = idx_nxt[AW-1:0];
            if (ent_free) begin
               run_in = run_inc;
               if (run_ff == '0) begin
                  start_in      = idx_ff;
                  start_addr_in = addr_ff;
               end
            end else begin
               run_in = '0;
            end
            if (ent_free && run_inc == want_ff) begin
               idx_in   = (run_ff == '0) ? idx_ff : start_ff;
               run_in   = want_ff;
               state_in = ST_MARK;
            end else if (idx_nxt == heap_n) begin
               res_status_in = STATUS_NOMEM;
               state_in      = ST_DONE;
            end
         end

         ST_MARK: begin
            ram_we               = 1'b1;
            ram_wdata[ENT_TAKEN] = 1'b1;
            ram_wdata[ENT_FIRST] = (idx_ff == start_ff);
            ram_wdata[ENT_NEXT]  = (run_ff != NW'(1));
            idx_in = idx_nxt;
            run_in = run_ff - NW'(1);
            if (run_ff == NW'(1)) begin
               res_addr_in   = start_addr_ff;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end
         end

         // clear the entry just read, follow has-next, stopping at the heap end
         ST_WALK: begin
            ram_we = 1'b1;
            if (ram_rdata[ENT_NEXT] && idx_nxt != heap_n) begin
               idx_in    = idx_nxt;
               ram_raddr = idx_nxt[AW-1:0];
            end else begin
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result_address = res_addr_ff;
               rsp_in.status         = res_status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= 32'd0;
         blocks_ff    <= BLOCKS_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_base_ff <= heap_base_in;
         blocks_ff    <= blocks_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      dvd_ff        <= dvd_in;
      run_ff        <= run_in;
      want_ff       <= want_in;
      start_ff      <= start_in;
      addr_ff       <= addr_in;
      start_addr_ff <= start_addr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // block table
   bthalloc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // checks
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !ram_we)
      else $error("table written during scan");

   a_scan_run_short: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> run_ff < want_ff)
      else $error("scan run reached request without marking");

   a_mark_taken: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> ram_we && ram_wdata[ENT_TAKEN])
      else $error("mark wrote a free entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done");

endmodule

[rtl/core/bthalloc_ram.sv]
module bthalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
